### rtl/monochrome_line_raster_engine_defines.svh
// Assertion macros shared by the raster engine RTL.
// Define NO_ASSERTIONS to compile them away.
`ifndef MONOCHROME_LINE_RASTER_ENGINE_DEFINES_SVH
`define MONOCHROME_LINE_RASTER_ENGINE_DEFINES_SVH
`ifndef NO_ASSERTIONS
`define ASSERT_IMPLIES(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");
`else
`define ASSERT_IMPLIES(label, clk, rst, ante, cons)
`define ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

### rtl/mlr_pkg.sv
// Shared types, codes and widths for the monochrome line raster engine.
// No dependencies.
package mlr_pkg;

   localparam int DEF_SCREEN_WIDTH  = 128;
   localparam int DEF_SCREEN_HEIGHT = 64;

   localparam int COORD_W  = 11;   // signed coordinate
   localparam int SPAN_W   = 12;   // |end - start|
   localparam int ERR_W    = 15;   // signed error term
   localparam int BUDGET_W = 13;   // span_x + span_y + 1

   // request kinds
   localparam logic [1:0] REQ_FILL_WHITE = 2'd0;
   localparam logic [1:0] REQ_FILL_BLACK = 2'd1;
   localparam logic [1:0] REQ_DRAW_LINE  = 2'd2;
   localparam logic [1:0] REQ_READ_PIXEL = 2'd3;

   // frame buffer operations
   localparam logic [1:0] MEM_NOP  = 2'd0;
   localparam logic [1:0] MEM_SET  = 2'd1;
   localparam logic [1:0] MEM_FILL = 2'd2;
   localparam logic [1:0] MEM_READ = 2'd3;

   typedef struct packed {
      logic [1:0] op;
      logic       fill_val;
   } mem_cmd_type;

   typedef struct packed {
      logic                      valid;
      logic signed [COORD_W-1:0] x;
      logic signed [COORD_W-1:0] y;
   } plot_type;

endpackage

### rtl/mlr_if.sv
// Request and response channel interfaces (valid/ready).
// Depends on mlr_pkg.
interface mlr_req_if import mlr_pkg::*; ();
   logic                      valid;
   logic                      ready;
   logic [1:0]                req_type;
   logic signed [COORD_W-1:0] start_x;
   logic signed [COORD_W-1:0] start_y;
   logic signed [COORD_W-1:0] end_x;
   logic signed [COORD_W-1:0] end_y;

   modport source (output valid, req_type, start_x, start_y, end_x, end_y, input ready);
   modport sink   (input valid, req_type, start_x, start_y, end_x, end_y, output ready);
endinterface

interface mlr_rsp_if import mlr_pkg::*; ();
   logic valid;
   logic ready;
   logic pixel_value;

   modport source (output valid, pixel_value, input ready);
   modport sink   (input valid, pixel_value, output ready);
endinterface

### rtl/mlr_fb_mem.sv
// Row-organized frame buffer: one row of pixels per word, registered read,
// pixel set done as read-modify-write with forwarding. Depends on mlr_pkg.
`include "monochrome_line_raster_engine_defines.svh"
module mlr_fb_mem import mlr_pkg::*; #(
   parameter int SCREEN_WIDTH  = DEF_SCREEN_WIDTH,
   parameter int SCREEN_HEIGHT = DEF_SCREEN_HEIGHT,
   localparam int ROW_W = $clog2(SCREEN_HEIGHT),
   localparam int COL_W = $clog2(SCREEN_WIDTH)
) (
   input  logic             clock,
   input  logic             reset,
   input  mem_cmd_type      cmd,
   input  logic [ROW_W-1:0] row,
   input  logic [COL_W-1:0] col,
   output logic             rd_bit
);

   logic [SCREEN_WIDTH-1:0] mem [SCREEN_HEIGHT];

   logic [1:0]              s1_op_ff;
   logic [ROW_W-1:0]        s1_row_ff;
   logic [COL_W-1:0]        s1_col_ff;
   logic [SCREEN_WIDTH-1:0] rdata_ff;
   logic [SCREEN_WIDTH-1:0] fwd_ff;
   logic                    hit_ff;

   logic                    we;
   logic [ROW_W-1:0]        waddr;
   logic [SCREEN_WIDTH-1:0] wdata;
   logic [SCREEN_WIDTH-1:0] cur;
   logic                    rd_req;

   assign rd_req = (cmd.op == MEM_SET) || (cmd.op == MEM_READ);
   // row written last cycle is not yet visible in rdata_ff
   assign cur    = hit_ff ? fwd_ff : rdata_ff;

   always_comb begin
      we    = 1'b0;
      waddr = row;
      wdata = {SCREEN_WIDTH{cmd.fill_val}};
      if (s1_op_ff == MEM_SET) begin
         we    = 1'b1;
         waddr = s1_row_ff;
         wdata = cur | ({{(SCREEN_WIDTH-1){1'b0}}, 1'b1} << s1_col_ff);
      end else if (cmd.op == MEM_FILL) begin
         we = 1'b1;
      end
   end

   assign rd_bit = cur[s1_col_ff];

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_req) begin
         rdata_ff <= mem[row];
      end
      s1_row_ff <= row;
      s1_col_ff <= col;
      fwd_ff    <= wdata;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_op_ff <= MEM_NOP;
         hit_ff   <= 1'b0;
      end else begin
         s1_op_ff <= rd_req ? cmd.op : MEM_NOP;
         hit_ff   <= rd_req && we && (waddr == row);
      end
   end

   `ASSERT_IMPLIES(a_fill_excludes_set, clock, reset, cmd.op == MEM_FILL, s1_op_ff != MEM_SET)
   `ASSERT_NEXT(a_hit_needs_write, clock, reset, !we, !hit_ff)

endmodule

### rtl/mlr_line_walker.sv
// Error-term line stepper: emits one point per cycle from start to end,
// endpoint included. Depends on mlr_pkg.
`include "monochrome_line_raster_engine_defines.svh"
module mlr_line_walker import mlr_pkg::*; (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      start,
   input  logic signed [COORD_W-1:0] x0,
   input  logic signed [COORD_W-1:0] y0,
   input  logic signed [COORD_W-1:0] x1,
   input  logic signed [COORD_W-1:0] y1,
   output plot_type                  plot,
   output logic                      done
);

   localparam logic [1:0] W_IDLE = 2'd0;
   localparam logic [1:0] W_SPAN = 2'd1;
   localparam logic [1:0] W_PREP = 2'd2;
   localparam logic [1:0] W_WALK = 2'd3;

   logic [1:0]                wst_ff, wst_in;
   logic signed [COORD_W-1:0] x_ff, x_in, y_ff, y_in, xe_ff, ye_ff;
   logic                      sx_neg_ff, sy_neg_ff;
   logic [SPAN_W-1:0]         spx_ff, spy_ff;
   logic signed [ERR_W-1:0]   xlim_ff, err_ff, err_in;
   logic [BUDGET_W-1:0]       budget_ff;

   logic signed [SPAN_W-1:0]  dx, dy;
   logic signed [ERR_W-1:0]   spx_e, spy_e, twx_e, twy_e, err1;
   logic                      c1, c2, at_end;

   assign dx = {xe_ff[COORD_W-1], xe_ff} - {x_ff[COORD_W-1], x_ff};
   assign dy = {ye_ff[COORD_W-1], ye_ff} - {y_ff[COORD_W-1], y_ff};

   assign spx_e = $signed({{(ERR_W-SPAN_W){1'b0}}, spx_ff});
   assign spy_e = $signed({{(ERR_W-SPAN_W){1'b0}}, spy_ff});
   assign twx_e = $signed({{(ERR_W-SPAN_W-1){1'b0}}, spx_ff, 1'b0});
   assign twy_e = $signed({{(ERR_W-SPAN_W-1){1'b0}}, spy_ff, 1'b0});

   // one step of the walk
   always_comb begin
      c1   = (err_ff <= xlim_ff);
      err1 = c1 ? err_ff + twy_e : err_ff;
      x_in = x_ff;
      if (c1) begin
         x_in = sx_neg_ff ? COORD_W'(x_ff - 1) : COORD_W'(x_ff + 1);
      end
      c2     = (err1 >= spx_e) || (spx_ff < spy_ff);
      err_in = c2 ? err1 - twx_e : err1;
      y_in   = y_ff;
      if (c2) begin
         y_in = sy_neg_ff ? COORD_W'(y_ff - 1) : COORD_W'(y_ff + 1);
      end
   end

   assign at_end     = (x_ff == xe_ff) && (y_ff == ye_ff);
   assign plot.valid = (wst_ff == W_WALK);
   assign plot.x     = x_ff;
   assign plot.y     = y_ff;
   assign done       = (wst_ff == W_WALK) && (at_end || (budget_ff == BUDGET_W'(1)));

   always_comb begin
      wst_in = wst_ff;
      unique case (wst_ff)
         W_IDLE: if (start) wst_in = W_SPAN;
         W_SPAN: wst_in = W_PREP;
         W_PREP: wst_in = W_WALK;
         W_WALK: if (done) wst_in = W_IDLE;
         default: wst_in = W_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wst_ff <= W_IDLE;
      end else begin
         wst_ff <= wst_in;
      end
   end

   always_ff @(posedge clock) begin
      case (wst_ff)
         W_IDLE: begin
            x_ff  <= x0;
            y_ff  <= y0;
            xe_ff <= x1;
            ye_ff <= y1;
         end
         W_SPAN: begin
            sx_neg_ff <= dx[SPAN_W-1];
            sy_neg_ff <= dy[SPAN_W-1];
            spx_ff    <= dx[SPAN_W-1] ? SPAN_W'(-dx) : SPAN_W'(dx);
            spy_ff    <= dy[SPAN_W-1] ? SPAN_W'(-dy) : SPAN_W'(dy);
         end
         W_PREP: begin
            xlim_ff   <= twx_e - spy_e;
            err_ff    <= '0;
            budget_ff <= BUDGET_W'(spx_ff) + BUDGET_W'(spy_ff) + BUDGET_W'(1);
         end
         default: begin
            x_ff      <= x_in;
            y_ff      <= y_in;
            err_ff    <= err_in;
            budget_ff <= budget_ff - BUDGET_W'(1);
         end
      endcase
   end

   `ASSERT_IMPLIES(a_done_on_plot, clock, reset, done, plot.valid)

endmodule

### rtl/monochrome_line_raster_engine.sv
// Monochrome line raster engine: one-bit frame buffer with fill, line
// draw and pixel read requests.
//
// Channels: req (sink) carries req_type, start_x, start_y, end_x, end_y;
// rsp (source) carries pixel_value. Both are valid/ready; a request or
// response moves on a clock edge with valid and ready high.
// Every request gives exactly one response. pixel_value is the pixel for
// a read (0 when off screen) and 0 for all other requests.
// Requests are handled one at a time. How each request is carried out:
//   fill white / fill black : one frame buffer row per cycle
//   draw line               : one point per cycle from start to end
//   read pixel              : one registered frame buffer read; none when off screen
// The frame buffer has a read port and a write port of one row per cycle each; pixel
// sets are read-modify-write with forwarding of the row written last.
// After reset the block clears the frame buffer to white, one row per
// cycle, with req.ready low throughout.
// A finished response waits in an output register; a new request is
// taken meanwhile, and its own response holds until that register frees.
// Depends on mlr_pkg, mlr_if, mlr_fb_mem, mlr_line_walker.
`include "monochrome_line_raster_engine_defines.svh"
module monochrome_line_raster_engine import mlr_pkg::*; #(
   parameter int SCREEN_WIDTH  = DEF_SCREEN_WIDTH,
   parameter int SCREEN_HEIGHT = DEF_SCREEN_HEIGHT
) (
   input logic       clock,
   input logic       reset,
   mlr_req_if.sink   req,
   mlr_rsp_if.source rsp
);

   localparam int ROW_W = $clog2(SCREEN_HEIGHT);
   localparam int COL_W = $clog2(SCREEN_WIDTH);

   localparam logic [2:0] ST_CLEAR      = 3'd0;
   localparam logic [2:0] ST_IDLE       = 3'd1;
   localparam logic [2:0] ST_LINE_START = 3'd2;
   localparam logic [2:0] ST_LINE_RUN   = 3'd3;
   localparam logic [2:0] ST_READ_ISSUE = 3'd4;
   localparam logic [2:0] ST_READ_WAIT  = 3'd5;
   localparam logic [2:0] ST_DONE       = 3'd6;

   logic [2:0]                state_ff, state_in;
   logic [ROW_W-1:0]          row_ff, row_in;
   logic                      clr_reply_ff, clr_reply_in;
   logic                      fill_val_ff, fill_val_in;
   logic                      value_ff, value_in;
   logic                      rsp_valid_ff, rsp_valid_in;
   logic                      rsp_value_ff, rsp_value_in;
   logic signed [COORD_W-1:0] x0_ff, y0_ff, x1_ff, y1_ff;

   mem_cmd_type               mem_cmd;
   logic [ROW_W-1:0]          mem_row;
   logic [COL_W-1:0]          mem_col;
   logic                      rd_bit;
   plot_type                  plot;
   logic                      line_done;
   logic                      accept;
   logic                      slot_free;

   function automatic logic in_frame(input logic signed [COORD_W-1:0] x,
                                     input logic signed [COORD_W-1:0] y);
      return !x[COORD_W-1] && ($signed({x[COORD_W-1], x}) < $signed((COORD_W+1)'(SCREEN_WIDTH)))
          && !y[COORD_W-1] && ($signed({y[COORD_W-1], y}) < $signed((COORD_W+1)'(SCREEN_HEIGHT)));
   endfunction

   assign req.ready       = (state_ff == ST_IDLE);
   assign accept          = req.valid && req.ready;
   assign slot_free       = !rsp_valid_ff || rsp.ready;
   assign rsp.valid       = rsp_valid_ff;
   assign rsp.pixel_value = rsp_value_ff;

   mlr_line_walker u_walker (
      .clock (clock),
      .reset (reset),
      .start (state_ff == ST_LINE_START),
      .x0    (x0_ff),
      .y0    (y0_ff),
      .x1    (x1_ff),
      .y1    (y1_ff),
      .plot  (plot),
      .done  (line_done)
   );

   mlr_fb_mem #(
      .SCREEN_WIDTH  (SCREEN_WIDTH),
      .SCREEN_HEIGHT (SCREEN_HEIGHT)
   ) u_fb (
      .clock  (clock),
      .reset  (reset),
      .cmd    (mem_cmd),
      .row    (mem_row),
      .col    (mem_col),
      .rd_bit (rd_bit)
   );

   always_comb begin
      state_in     = state_ff;
      row_in       = row_ff;
      clr_reply_in = clr_reply_ff;
      fill_val_in  = fill_val_ff;
      value_in     = value_ff;
      rsp_valid_in = rsp_valid_ff && !rsp.ready;
      rsp_value_in = rsp_value_ff;
      mem_cmd.op       = MEM_NOP;
      mem_cmd.fill_val = fill_val_ff;
      mem_row      = row_ff;
      mem_col      = '0;
      unique case (state_ff)
         ST_CLEAR: begin
            mem_cmd.op = MEM_FILL;
            if (row_ff == ROW_W'(SCREEN_HEIGHT - 1)) begin
               state_in = clr_reply_ff ? ST_DONE : ST_IDLE;
            end else begin
               row_in = row_ff + ROW_W'(1);
            end
         end
         ST_IDLE: begin
            if (accept) begin
               value_in = 1'b0;
               unique case (req.req_type) inside
                  REQ_FILL_WHITE, REQ_FILL_BLACK: begin
                     fill_val_in  = (req.req_type == REQ_FILL_BLACK);
                     clr_reply_in = 1'b1;
                     row_in       = '0;
                     state_in     = ST_CLEAR;
                  end
                  REQ_DRAW_LINE:  state_in = ST_LINE_START;
                  REQ_READ_PIXEL: state_in = ST_READ_ISSUE;
                  default:        state_in = ST_IDLE;
               endcase
            end
         end
         ST_LINE_START: state_in = ST_LINE_RUN;
         ST_LINE_RUN: begin
            mem_row = plot.y[ROW_W-1:0];
            mem_col = plot.x[COL_W-1:0];
            if (plot.valid && in_frame(plot.x, plot.y)) begin
               mem_cmd.op = MEM_SET;
            end
            if (line_done) begin
               state_in = ST_DONE;
            end
         end
         ST_READ_ISSUE: begin
            mem_row = y0_ff[ROW_W-1:0];
            mem_col = x0_ff[COL_W-1:0];
            if (in_frame(x0_ff, y0_ff)) begin
               mem_cmd.op = MEM_READ;
               state_in   = ST_READ_WAIT;
            end else begin
               state_in = ST_DONE;
            end
         end
         ST_READ_WAIT: begin
            value_in = rd_bit;
            state_in = ST_DONE;
         end
         ST_DONE: begin
            if (slot_free) begin
               rsp_valid_in = 1'b1;
               rsp_value_in = value_ff;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         row_ff       <= '0;
         clr_reply_ff <= 1'b0;
         fill_val_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         row_ff       <= row_in;
         clr_reply_ff <= clr_reply_in;
         fill_val_ff  <= fill_val_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      value_ff     <= value_in;
      rsp_value_ff <= rsp_value_in;
      if (accept) begin
         x0_ff <= req.start_x;
         y0_ff <= req.start_y;
         x1_ff <= req.end_x;
         y1_ff <= req.end_y;
      end
   end

   `ASSERT_IMPLIES(a_idle_quiet, clock, reset, state_ff == ST_IDLE, mem_cmd.op == MEM_NOP)
   `ASSERT_IMPLIES(a_done_in_run, clock, reset, line_done, state_ff == ST_LINE_RUN)
   `ASSERT_NEXT(a_read_wait, clock, reset, mem_cmd.op == MEM_READ, state_ff == ST_READ_WAIT)

endmodule
